@@ hdl/u8sc_pkg.sv @@
package u8sc_pkg;

  // Byte class masks
  localparam logic [7:0] TopBitMask = 8'h80;
  localparam logic [7:0] ContMask   = 8'hC0;

  localparam int unsigned PendW = 3;

  // Class of one byte as seen by the sequence tracker
  typedef struct packed {
    logic             top_bit;    // bit 7 set
    logic             is_cont;    // 10xxxxxx
    logic [PendW-1:0] cont_count; // continuations a lead of this form opens
  } byte_info_t;

  // Verdict of one string
  typedef struct packed {
    logic is_utf8;
    logic saw_non_ascii;
  } verdict_t;

endpackage

@@ hdl/utf8_sequence_check_unit.sv @@
// Verdicts: the verdict of a last item passes through the input register, then the result
//   register, where it waits until the receiver takes it; other items give none.
// Throughput: one transaction per cycle; the input side stalls only while a finished
//   verdict waits in the result register and the next staged item is also last.
// Reset: rst_ni low clears both valid flags and the string state (pending count,
//   high-bit and failure flags) at once; payload registers are not reset.
module utf8_sequence_check_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       carries_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       is_utf8_o,
  output logic       saw_non_ascii_o
);
  import u8sc_pkg::*;

  // Input stage
  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       has_q;
  logic       last_q;

  // Result stage
  logic       out_valid_q, out_valid_d;
  verdict_t   res_q;

  logic       out_free;
  logic       advance;
  logic       in_take;
  byte_info_t info;
  verdict_t   verdict;

  // The result register can load when empty or being drained this cycle
  assign out_free = !out_valid_q || out_ready_i;

  // Non-last items never need the result register, so they always advance
  assign advance    = in_valid_q && (!last_q || out_free);
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Hold the staged transaction until it advances
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= data_byte_i;
      has_q  <= carries_byte_i;
      last_q <= last_byte_i;
    end
  end

  u8sc_lead_decode u_decode (
    .data_byte_i (byte_q),
    .info_o      (info)
  );

  u8sc_track u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .has_byte_i (has_q),
    .is_last_i  (last_q),
    .info_i     (info),
    .verdict_o  (verdict)
  );

  // Load the verdict when a last item advances; drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && last_q) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      res_q <= verdict;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_utf8_o       = res_q.is_utf8;
  assign saw_non_ascii_o = res_q.saw_non_ascii;

endmodule

@@ hdl/u8sc_lead_decode.sv @@
module u8sc_lead_decode (
  input  logic [7:0]          data_byte_i,
  output u8sc_pkg::byte_info_t info_o
);
  import u8sc_pkg::*;

  logic [PendW-1:0] count;

  // Leading ones minus one (zero for a byte with no leading ones), in the pending counter width
  always_comb begin
    casez (data_byte_i)
      8'b0???????: count = PendW'(0);
      8'b10??????: count = PendW'(0);
      8'b110?????: count = PendW'(1);
      8'b1110????: count = PendW'(2);
      8'b11110???: count = PendW'(3);
      8'b111110??: count = PendW'(4);
      8'b1111110?: count = PendW'(5);
      8'b11111110: count = PendW'(6);
      default:     count = PendW'(7);
    endcase
  end

  assign info_o.top_bit    = (data_byte_i & TopBitMask) != 8'h00;
  assign info_o.is_cont    = (data_byte_i & ContMask) == TopBitMask;
  assign info_o.cont_count = count;

endmodule

@@ hdl/u8sc_track.sv @@
module u8sc_track (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  logic                 has_byte_i,
  input  logic                 is_last_i,
  input  u8sc_pkg::byte_info_t info_i,
  output u8sc_pkg::verdict_t   verdict_o
);
  import u8sc_pkg::*;

  logic [PendW-1:0] pend_q, pend_d, pend_n;
  logic             seen_q, seen_d, seen_n;
  logic             fail_q, fail_d, fail_n;

  // Effect of the current byte on the string state
  always_comb begin
    pend_n = pend_q;
    seen_n = seen_q | (has_byte_i & info_i.top_bit);
    fail_n = fail_q;
    if (has_byte_i && !fail_q) begin
      if (pend_q == '0) begin
        if (info_i.top_bit) begin
          if (info_i.is_cont) begin
            fail_n = 1'b1;
          end else begin
            pend_n = info_i.cont_count;
          end
        end
      end else if (!info_i.is_cont) begin
        fail_n = 1'b1;
      end else begin
        pend_n = pend_q - PendW'(1);
      end
    end
  end

  assign verdict_o.is_utf8       = !fail_n && (pend_n == '0) && seen_n;
  assign verdict_o.saw_non_ascii = seen_n;

  // Clear after the last item so the next string starts fresh
  always_comb begin
    pend_d = pend_q;
    seen_d = seen_q;
    fail_d = fail_q;
    if (advance_i) begin
      if (is_last_i) begin
        pend_d = '0;
        seen_d = 1'b0;
        fail_d = 1'b0;
      end else begin
        pend_d = pend_n;
        seen_d = seen_n;
        fail_d = fail_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      seen_q <= 1'b0;
      fail_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      seen_q <= seen_d;
      fail_q <= fail_d;
    end
  end

endmodule

@@ hdl/u8sc_checker.sv @@
module u8sc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       is_utf8_o,
  input logic       saw_non_ascii_o
);

  // A positive verdict needs a byte with the top bit set
  a_verdict_needs_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!is_utf8_o || saw_non_ascii_o))
    else $error("is_utf8 without saw_non_ascii");

  // Input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output backpressure");

  // No result while in reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(is_utf8_o) && $stable(saw_non_ascii_o)))
    else $error("result changed while stalled");

endmodule

bind utf8_sequence_check_unit u8sc_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .is_utf8_o       (is_utf8_o),
  .saw_non_ascii_o (saw_non_ascii_o)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import u8sc_pkg::*;

  localparam int ClkPeriod   = 12;
  localparam int ResetCycles = 7;
  localparam int ItemTarget  = 1400;
  // No transaction on either side for this long means the block is hung
  localparam int HangLimit   = 2000;
  // Extra wait after every expected verdict has drained, before closing out
  localparam int DrainCycles = 6;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] data_byte_i;
  logic       carries_byte_i;
  logic       last_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       is_utf8_o;
  logic       saw_non_ascii_o;

  // Per-string tracking state, mirrored from the block's behavior
  typedef struct packed {
    logic [PendW-1:0] pending;   // continuation bytes still owed
    logic             high_seen; // a byte with bit 7 set went by
    logic             failed;    // sticky until the string ends
  } string_state_t;

  string_state_t string_state;
  verdict_t      expected_verdicts[$];
  int            error_count = 0;
  int            items_sent;
  int            idle_watch = 0;
  bit            steady_flow; // when set, neither side inserts gaps

  utf8_sequence_check_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .carries_byte_i (carries_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .is_utf8_o      (is_utf8_o),
    .saw_non_ascii_o(saw_non_ascii_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Gap length: mostly none, sometimes a few cycles, now and then a long one
  function automatic int pick_gap();
    int roll;
    if (steady_flow) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int count_leading_ones(input logic [7:0] b);
    int n;
    n = 0;
    for (int i = 7; i >= 0; i--) begin
      if (!b[i]) break;
      n++;
    end
    return n;
  endfunction

  // Fold one accepted transaction into the string state; a last item
  // produces a verdict and clears the state for the next string.
  task automatic absorb_item(input logic [7:0] b, input logic has_byte, input logic fin);
    verdict_t v;
    int       ones;
    if (has_byte) begin
      if ((b & TopBitMask) != 8'h00) string_state.high_seen = 1'b1;
      if (!string_state.failed) begin
        if (string_state.pending == '0) begin
          if ((b & TopBitMask) != 8'h00) begin
            ones = count_leading_ones(b);
            // a continuation byte cannot open a sequence
            if (ones == 1) string_state.failed = 1'b1;
            else string_state.pending = PendW'(ones - 1);
          end
        end else if ((b & ContMask) != TopBitMask) begin
          string_state.failed = 1'b1;
        end else begin
          string_state.pending = string_state.pending - 1'b1;
        end
      end
    end
    if (fin) begin
      v.is_utf8 = !string_state.failed && string_state.pending == '0 &&
                  string_state.high_seen;
      v.saw_non_ascii = string_state.high_seen;
      expected_verdicts = {expected_verdicts, v};
      string_state = '0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Present one transaction at a falling edge and hold it until accepted
  task automatic send_item(input logic [7:0] b, input logic has_byte, input logic fin);
    int idle;
    idle = pick_gap();
    if (idle > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (idle - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    data_byte_i    <= b;
    carries_byte_i <= has_byte;
    last_byte_i    <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    absorb_item(b, has_byte, fin);
    if (has_byte || fin) items_sent++;
  endtask

  // Send a whole string; with_marker ends it with a byteless last item.
  // Byteless non-last items are sprinkled in now and then; they must be ignored.
  task automatic send_string(input logic [7:0] str[$], input bit with_marker);
    for (int i = 0; i < str.size(); i++) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(str[i], 1'b1, !with_marker && i == str.size() - 1);
    end
    if (with_marker || str.size() == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Lead byte with n leading ones followed by a zero (when n < 8) and random low bits
  function automatic logic [7:0] lead_byte(input int n);
    logic [7:0] ones;
    logic [7:0] low;
    ones = 8'hFF << (8 - n);
    low  = 8'($urandom) & (8'hFF >> (n + 1));
    return ones | low;
  endfunction

  // Empty strings, byteless items, zero byte, plain ASCII
  task automatic test_empty_strings();
    logic [7:0] str[$];
    str.delete();
    send_string(str, 1'b1);
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    str = '{8'h7F};
    send_string(str, 1'b0);
  endtask

  // Valid multi-byte forms, including a lead that opens seven continuations
  task automatic test_well_formed_sequences();
    logic [7:0] str[$];
    str = '{8'hC2, 8'h80};
    send_string(str, 1'b0);
    str = '{8'hFF, 8'hBF, 8'h80, 8'hBF, 8'h80, 8'hBF, 8'h80, 8'hBF};
    send_string(str, 1'b0);
    // end a non-empty string with a byteless last item
    str = '{8'hC2, 8'h80};
    send_string(str, 1'b1);
  endtask

  // Stray continuation, missing continuation, open sequence at the end,
  // and bytes arriving after the string has already failed
  task automatic test_malformed_sequences();
    logic [7:0] str[$];
    str = '{8'h80};
    send_string(str, 1'b0);
    str = '{8'hE2, 8'h41};
    send_string(str, 1'b0);
    str = '{8'hF0, 8'h9F};
    send_string(str, 1'b0);
    str = '{8'h80, 8'hC2, 8'h80};
    send_string(str, 1'b0);
  endtask

  // Back-to-back single-item strings, first with a receiver that is always ready, then
  // with a stalling one, against which the input side is supposed to push back
  task automatic test_verdict_backpressure();
    steady_flow = 1'b1;
    repeat (30) send_item(8'($urandom), 1'($urandom), 1'b1);
    steady_flow = 1'b0;
    repeat (30) send_item(8'($urandom), 1'($urandom), 1'b1);
  endtask

  // Mostly well-formed strings with random content, plus noise and damaged strings
  task automatic test_random_strings();
    logic [7:0] str[$];
    int         kind;
    int         n_chars;
    int         n;
    while (items_sent < ItemTarget) begin
      str.delete();
      steady_flow = ($urandom_range(0, 7) == 0);
      kind    = $urandom_range(0, 9);
      n_chars = $urandom_range(0, 6);
      for (int c = 0; c < n_chars; c++) begin
        if ($urandom_range(0, 2) == 0) begin
          str = {str, 8'($urandom_range(0, 127))};
        end else begin
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 8) : $urandom_range(2, 4);
          str = {str, lead_byte(n)};
          repeat (n - 1) str = {str, 8'h80 | 8'($urandom_range(0, 63))};
        end
      end
      case (kind)
        0: begin
          // raw noise
          str.delete();
          repeat ($urandom_range(1, 8)) str = {str, 8'($urandom)};
        end
        1: begin
          // overwrite one byte
          if (str.size() > 0) str[$urandom_range(0, str.size() - 1)] = 8'($urandom);
        end
        2: begin
          // cut the string short, usually leaving a sequence open
          if (str.size() > 1) void'(str.pop_back());
        end
        default: ;
      endcase
      send_string(str, str.size() == 0 || $urandom_range(0, 9) == 0);
    end
    steady_flow = 1'b0;
  endtask

  // Receiver: stall for a random number of cycles between ready windows
  initial begin : receiver_stall
    int hold;
    hold = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  // Check each verdict the block hands over against the oldest expectation
  always @(posedge clk_i) begin : verdict_check
    verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("verdict with none pending (is_utf8=%0b saw_non_ascii=%0b)",
                                  is_utf8_o, saw_non_ascii_o));
      end else begin
        want = expected_verdicts.pop_front();
        if (is_utf8_o !== want.is_utf8)
          report_mismatch($sformatf("is_utf8 expected %0b got %0b",
                                    want.is_utf8, is_utf8_o));
        if (saw_non_ascii_o !== want.saw_non_ascii)
          report_mismatch($sformatf("saw_non_ascii expected %0b got %0b",
                                    want.saw_non_ascii, saw_non_ascii_o));
      end
    end
  end

  // Hang detection: restart the count on any transaction, either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_watch <= 0;
    else idle_watch <= idle_watch + 1;
    if (idle_watch >= HangLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, HangLimit);
      $display("[utf8_sequence_check_unit] ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    data_byte_i    = 8'h00;
    carries_byte_i = 1'b0;
    last_byte_i    = 1'b0;
    string_state   = '0;
    items_sent     = 0;
    steady_flow    = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_strings();
    test_well_formed_sequences();
    test_malformed_sequences();
    test_verdict_backpressure();
    test_random_strings();

    // drop valid, let every pending verdict drain, then allow for latency
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[utf8_sequence_check_unit] OK");
    end else begin
      $display("[utf8_sequence_check_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/u8sc_pkg.sv
hdl/u8sc_lead_decode.sv
hdl/u8sc_track.sv
hdl/utf8_sequence_check_unit.sv
hdl/u8sc_checker.sv
sim/tb_top.sv
